// File: design/acmg_pkg.sv
// ----------------------------------------------------------------------------
// acmg_pkg: shared types and constants for the motion-gated alarm clock
// Time-of-day state, input beat fields, operation and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acmg_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_ADJ_CUR = 2'd1,
		OP_ADJ_ALM = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_DAY_LIMIT = 2'd0,
		CFG_TICKS     = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		VIEW_CUR24 = 2'd0,
		VIEW_ALM24 = 2'd1,
		VIEW_ALM12 = 2'd2,
		VIEW_CUR12 = 2'd3
	} view_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [2:0] DAY_LIMIT_RST = 3'd5;
	localparam logic [4:0] TICKS_RST     = 5'd4;

	localparam logic [5:0] CUR_SEC_RST = 6'd45;
	localparam logic [5:0] CUR_MIN_RST = 6'd10;
	localparam logic [4:0] CUR_HR_RST  = 5'd22;
	localparam logic [2:0] WDAY_RST    = 3'd3;
	localparam logic [5:0] ALM_SEC_RST = 6'd50;
	localparam logic [5:0] ALM_MIN_RST = 6'd10;
	localparam logic [4:0] ALM_HR_RST  = 5'd22;

	localparam logic [2:0] LAST_DAY  = 3'd6;
	localparam logic [4:0] MAX_TICKS = 5'd16;
	localparam logic [4:0] HALF_DAY  = 5'd12;
	localparam logic [7:0] SEG_BLANK = 8'h7F;

	typedef struct packed {
		logic [1:0] op;
		logic       unit_sec;
		logic       down;
		logic       still;
		logic       sw_on;
		logic [1:0] view;
	} item_t;

	typedef struct packed {
		logic [5:0] cur_sec;
		logic [5:0] cur_min;
		logic [4:0] cur_hr;
		logic [2:0] wday;
		logic [5:0] alm_sec;
		logic [5:0] alm_min;
		logic [4:0] alm_hr;
		logic       ring;
	} time_t;

	typedef struct packed {
		logic [2:0] day_limit;
		logic [4:0] ticks;
	} cfg_t;

endpackage

// File: design/acmg_time_unit.sv
// ----------------------------------------------------------------------------
// acmg_time_unit: clock and alarm state with single-beat next-state logic
// Ticks, carries, adjusts and the alarm latch; state loads on each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acmg_time_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  acmg_pkg::item_t item,
	input  acmg_pkg::cfg_t  cfg,
	output acmg_pkg::time_t nxt
);

	acmg_pkg::time_t state_q;
	logic [3:0]      tick_q;
	logic [3:0]      tick_d;
	logic [4:0]      tick_lim;
	logic [4:0]      tick_inc;
	logic [6:0]      sec_add;
	logic [6:0]      sec_sum;
	logic [6:0]      sec_wrap;
	logic [6:0]      alm_sum;
	logic [6:0]      alm_wrap;
	logic            min_up;
	logic            min_dn;
	logic            hr_up;
	logic            hr_dn;
	logic            match;

	always_comb begin
		nxt      = state_q;
		tick_d   = tick_q;
		sec_add  = '0;
		sec_sum  = '0;
		sec_wrap = '0;
		alm_sum  = '0;
		alm_wrap = '0;
		min_up   = 1'b0;
		min_dn   = 1'b0;
		hr_up    = 1'b0;
		hr_dn    = 1'b0;
		match    = 1'b0;

		if (cfg.ticks == 5'd0) begin
			tick_lim = 5'd1;
		end else if (cfg.ticks > acmg_pkg::MAX_TICKS) begin
			tick_lim = acmg_pkg::MAX_TICKS;
		end else begin
			tick_lim = cfg.ticks;
		end
		tick_inc = {1'b0, tick_q} + 5'd1;

		// motion drops the latch before anything else
		if (!item.still) begin
			nxt.ring = 1'b0;
		end

		case (item.op)
			acmg_pkg::OP_TICK: begin
				if (tick_inc >= tick_lim) begin
					tick_d  = '0;
					sec_add = 7'd1;
				end else begin
					tick_d = tick_inc[3:0];
				end
			end
			acmg_pkg::OP_ADJ_CUR: begin
				if (item.unit_sec) begin
					if (!item.down) begin
						sec_add = 7'd10;
					end else if (state_q.cur_sec < 6'd10) begin
						nxt.cur_sec = state_q.cur_sec + 6'd50;
						min_dn      = 1'b1;
					end else begin
						nxt.cur_sec = state_q.cur_sec - 6'd10;
					end
				end else begin
					min_up = !item.down;
					min_dn = item.down;
				end
			end
			acmg_pkg::OP_ADJ_ALM: begin
				// alarm fields wrap on their own, no carry
				if (item.unit_sec) begin
					alm_sum  = {1'b0, state_q.alm_sec} + (item.down ? 7'd50 : 7'd10);
					alm_wrap = alm_sum - 7'd60;
					nxt.alm_sec = (alm_sum >= 7'd60) ? alm_wrap[5:0] : alm_sum[5:0];
				end else begin
					alm_sum  = {1'b0, state_q.alm_min} + (item.down ? 7'd59 : 7'd1);
					alm_wrap = alm_sum - 7'd60;
					nxt.alm_min = (alm_sum >= 7'd60) ? alm_wrap[5:0] : alm_sum[5:0];
				end
			end
			default: ;
		endcase

		if (sec_add != 7'd0) begin
			sec_sum  = {1'b0, state_q.cur_sec} + sec_add;
			sec_wrap = sec_sum - 7'd60;
			if (sec_sum >= 7'd60) begin
				nxt.cur_sec = sec_wrap[5:0];
				min_up      = 1'b1;
			end else begin
				nxt.cur_sec = sec_sum[5:0];
			end
		end

		if (min_up) begin
			if (state_q.cur_min >= 6'd59) begin
				nxt.cur_min = '0;
				hr_up       = 1'b1;
			end else begin
				nxt.cur_min = state_q.cur_min + 6'd1;
			end
		end else if (min_dn) begin
			if (state_q.cur_min == 6'd0) begin
				nxt.cur_min = 6'd59;
				hr_dn       = 1'b1;
			end else begin
				nxt.cur_min = state_q.cur_min - 6'd1;
			end
		end

		if (hr_up) begin
			if (state_q.cur_hr >= 5'd23) begin
				nxt.cur_hr = '0;
				nxt.wday   = (state_q.wday >= acmg_pkg::LAST_DAY) ? 3'd0 : state_q.wday + 3'd1;
			end else begin
				nxt.cur_hr = state_q.cur_hr + 5'd1;
			end
		end else if (hr_dn) begin
			if (state_q.cur_hr == 5'd0) begin
				nxt.cur_hr = 5'd23;
				nxt.wday   = (state_q.wday == 3'd0 || state_q.wday > acmg_pkg::LAST_DAY) ?
				             acmg_pkg::LAST_DAY : state_q.wday - 3'd1;
			end else begin
				nxt.cur_hr = state_q.cur_hr - 5'd1;
			end
		end

		match = (nxt.cur_hr == nxt.alm_hr) && (nxt.cur_min == nxt.alm_min) &&
		        (nxt.cur_sec == nxt.alm_sec);
		if (item.still && match && (nxt.wday < cfg.day_limit)) begin
			nxt.ring = 1'b1;
		end
		if (item.still && !item.sw_on) begin
			nxt.ring = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cur_sec <= acmg_pkg::CUR_SEC_RST;
			state_q.cur_min <= acmg_pkg::CUR_MIN_RST;
			state_q.cur_hr  <= acmg_pkg::CUR_HR_RST;
			state_q.wday    <= acmg_pkg::WDAY_RST;
			state_q.alm_sec <= acmg_pkg::ALM_SEC_RST;
			state_q.alm_min <= acmg_pkg::ALM_MIN_RST;
			state_q.alm_hr  <= acmg_pkg::ALM_HR_RST;
			state_q.ring    <= 1'b0;
			tick_q          <= '0;
		end else if (load) begin
			state_q <= nxt;
			tick_q  <= tick_d;
		end
	end

endmodule

// File: design/acmg_display.sv
// ----------------------------------------------------------------------------
// acmg_display: view selection and seven-segment encoding
// Picks current or alarm time, folds hours to 12-hour form in the 12-hour views, splits into digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acmg_display (
	input  acmg_pkg::time_t t,
	input  logic [1:0]      view,
	output logic [31:0]     min_sec_seg,
	output logic [15:0]     hour_seg
);

	function automatic logic [2:0] dec_tens(input logic [5:0] v);
		logic [2:0] r;
		if (v >= 6'd60)      r = 3'd6;
		else if (v >= 6'd50) r = 3'd5;
		else if (v >= 6'd40) r = 3'd4;
		else if (v >= 6'd30) r = 3'd3;
		else if (v >= 6'd20) r = 3'd2;
		else if (v >= 6'd10) r = 3'd1;
		else                 r = 3'd0;
		return r;
	endfunction

	function automatic logic [3:0] dec_units(input logic [5:0] v);
		logic [2:0] tn;
		logic [5:0] r;
		tn = dec_tens(v);
		r  = v - {tn, 3'b000} - {2'b00, tn, 1'b0};
		return r[3:0];
	endfunction

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] r;
		case (d)
			4'd0:    r = 8'h40;
			4'd1:    r = 8'h79;
			4'd2:    r = 8'h24;
			4'd3:    r = 8'h30;
			4'd4:    r = 8'h19;
			4'd5:    r = 8'h12;
			4'd6:    r = 8'h02;
			4'd7:    r = 8'h78;
			4'd8:    r = 8'h00;
			4'd9:    r = 8'h10;
			default: r = acmg_pkg::SEG_BLANK;
		endcase
		return r;
	endfunction

	logic       show_alm;
	logic       twelve_hr;
	logic [5:0] m;
	logic [5:0] s;
	logic [4:0] h_raw;
	logic [5:0] h;

	always_comb begin
		show_alm  = (view == acmg_pkg::VIEW_ALM24) || (view == acmg_pkg::VIEW_ALM12);
		twelve_hr = (view == acmg_pkg::VIEW_ALM12) || (view == acmg_pkg::VIEW_CUR12);
		m     = show_alm ? t.alm_min : t.cur_min;
		s     = show_alm ? t.alm_sec : t.cur_sec;
		h_raw = show_alm ? t.alm_hr : t.cur_hr;
		if (twelve_hr && (h_raw > acmg_pkg::HALF_DAY)) begin
			h = {1'b0, h_raw - acmg_pkg::HALF_DAY};
		end else begin
			h = {1'b0, h_raw};
		end
		min_sec_seg = {seg_code({1'b0, dec_tens(m)}), seg_code(dec_units(m)),
		               seg_code({1'b0, dec_tens(s)}), seg_code(dec_units(s))};
		hour_seg    = {seg_code({1'b0, dec_tens(h)}), seg_code(dec_units(h))};
	end

endmodule

// File: design/alarm_clock_with_motion_gate_core.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_motion_gate_core: 24-hour alarm clock with motion gate
// Output: the result beat of an accepted input beat is registered in the next cycle.
// Throughput: one beat per cycle while out_ready holds; the output register frees as it drains.
// Reset: time 22:10:45 day 3, alarm 22:10:50, latch off, limit 5, 4 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_clock_with_motion_gate_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [acmg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acmg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic                             adjust_unit,
	input  logic                             adjust_down,
	input  logic                             board_still,
	input  logic                             alarm_switch,
	input  logic [1:0]                       view_select,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      min_sec_segments,
	output logic [15:0]                      hour_segments,
	output logic                             ringing,
	output logic                             alarm_led,
	output logic [2:0]                       day_number
);

	acmg_pkg::item_t item;
	acmg_pkg::cfg_t  cfg_q;
	acmg_pkg::time_t nxt;
	logic            accept;
	logic            out_valid_q;
	logic [31:0]     min_sec_seg;
	logic [15:0]     hour_seg;
	logic [31:0]     min_sec_q;
	logic [15:0]     hour_q;
	logic            ring_q;
	logic            led_q;
	logic [2:0]      day_q;

	assign item.op       = operation;
	assign item.unit_sec = adjust_unit;
	assign item.down     = adjust_down;
	assign item.still    = board_still;
	assign item.sw_on    = alarm_switch;
	assign item.view     = view_select;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.day_limit <= acmg_pkg::DAY_LIMIT_RST;
			cfg_q.ticks     <= acmg_pkg::TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acmg_pkg::CFG_DAY_LIMIT: cfg_q.day_limit <= cfg_data[2:0];
				acmg_pkg::CFG_TICKS:     cfg_q.ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

	acmg_time_unit u_time (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.item   (item),
		.cfg    (cfg_q),
		.nxt    (nxt)
	);

	acmg_display u_disp (
		.t           (nxt),
		.view        (view_select),
		.min_sec_seg (min_sec_seg),
		.hour_seg    (hour_seg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			min_sec_q <= min_sec_seg;
			hour_q    <= hour_seg;
			ring_q    <= nxt.ring;
			led_q     <= board_still && alarm_switch;
			day_q     <= nxt.wday;
		end
	end

	assign out_valid        = out_valid_q;
	assign min_sec_segments = min_sec_q;
	assign hour_segments    = hour_q;
	assign ringing          = ring_q;
	assign alarm_led        = led_q;
	assign day_number       = day_q;

`ifndef NO_ASSERTIONS
	a_motion_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !board_still) |=> (out_valid && !ringing))
		else $error("ringing survived motion");

	a_switch_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && board_still && !alarm_switch) |=> (out_valid && !ringing))
		else $error("ringing survived switch off");

	a_led_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (alarm_led == $past(board_still && alarm_switch)))
		else $error("alarm led mismatch");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day_number <= acmg_pkg::LAST_DAY))
		else $error("weekday out of range");
`endif

endmodule
